/* src/trajectory_table_interpolator_defines.svh */
`ifndef TRAJECTORY_TABLE_INTERPOLATOR_DEFINES_SVH
`define TRAJECTORY_TABLE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication check, clocked on clk, off while arst_n is low.
`define TTI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

// Next-cycle implication check, clocked on clk, off while arst_n is low.
`define TTI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

/* src/ttint_pkg.sv */
package ttint_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RS_LO    = 2'd0,
		RS_HI    = 2'd1,
		RS_PROBE = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		LANE_X = 2'd0,
		LANE_Y = 2'd1,
		LANE_T = 2'd2
	} lane_t;

	typedef struct packed {
		logic    clr;
		logic    wr;
		logic    load_z;
		logic    init_br;
		rd_sel_t rd_sel;
		logic    cap_lo_row;
		logic    cap_hi_row;
		logic    mul_gap;
		logic    div_start;
		logic    div_weight;
		logic    set_probe;
		logic    upd_br;
		logic    cap_w;
		logic    mul_en;
		lane_t   mul_lane;
		logic    sum_en;
		lane_t   sum_lane;
		logic    res_en;
		status_t res_status;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic out_range;
		logic gap_gt1;
		logic div_done;
	} sts_t;

endpackage

/* src/ttint_div.sv */
module ttint_div #(
	parameter int unsigned NW = 44,
	parameter int unsigned DW = 33,
	parameter int unsigned QB = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QB-1:0] quot
);

	localparam int unsigned HW = ((NW - QB) > DW) ? (NW - QB) : DW;
	localparam int unsigned CW = $clog2(QB + 1);

	logic [HW-1:0] top_ext;
	logic          ovf;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QB-1:0] nlow_q;
	logic [QB-1:0] quot_q;

	// A quotient that would not fit saturates to all ones.
	assign top_ext = HW'(num[NW-1:QB]);
	assign ovf     = top_ext >= HW'(den);
	assign trial   = {rem_q, nlow_q[QB-1]};
	assign diff    = trial - {1'b0, den_q};
	assign ge      = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CW'(QB);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (ovf) begin
				quot_q <= '1;
			end else begin
				rem_q  <= top_ext[DW-1:0];
				nlow_q <= num[QB-1:0];
				den_q  <= den;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			nlow_q <= {nlow_q[QB-2:0], 1'b0};
			quot_q <= {quot_q[QB-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* src/ttint_dp.sv */
`include "trajectory_table_interpolator_defines.svh"

module ttint_dp #(
	parameter int unsigned TABLE_DEPTH = 1024,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ttint_pkg::cmd_t   cmd,
	output ttint_pkg::sts_t   sts,
	input  logic [127:0]      in_data,
	output logic [1:0]        out_status,
	output logic [95:0]       out_data
);

	localparam int unsigned IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned QB   = ((IDXW > FRAC_BITS) ? IDXW : FRAC_BITS) + 1;
	localparam int unsigned NW   = ((IDXW + 34) > (FRAC_BITS + 33)) ?
		(IDXW + 34) : (FRAC_BITS + 33);
	localparam int unsigned DW   = 33;
	localparam int unsigned PW   = FRAC_BITS + 34;

	logic [31:0] mem_x [TABLE_DEPTH];
	logic [31:0] mem_y [TABLE_DEPTH];
	logic [31:0] mem_z [TABLE_DEPTH];
	logic [31:0] mem_t [TABLE_DEPTH];

	logic [CNTW-1:0] count_q;
	logic [IDXW-1:0] lo_q, hi_q, probe_q;
	logic [IDXW-1:0] raddr;
	logic [31:0]     rd_x_q, rd_y_q, rd_z_q, rd_t_q;
	logic signed [31:0] z_q, zlo_q, zhi_q, zp;
	logic [31:0]     lo_x_q, lo_y_q, lo_t_q, hi_x_q, hi_y_q, hi_t_q;
	logic [IDXW+31:0] prod_s1;
	logic [FRAC_BITS:0] w_q, one_m_w;
	logic signed [PW-1:0] pa_s1, pb_s1;
	logic signed [PW:0]   sum;
	logic [31:0]     vlo, vhi;
	logic [1:0]      res_status_q;
	logic [31:0]     res_x_q, res_y_q, res_t_q;
	logic [1:0]      out_status_q;
	logic [31:0]     out_x_q, out_y_q, out_t_q;

	logic signed [32:0] d, den, dzc;
	logic [IDXW-1:0] gap, gapm1;
	logic            probe_ok, den_pos, full;
	logic [NW-1:0]   div_num;
	logic [DW-1:0]   div_den;
	logic            div_done;
	logic [QB-1:0]   quot, off, offc;

	assign full     = count_q == CNTW'(TABLE_DEPTH);
	assign gap      = hi_q - lo_q;
	assign gapm1    = gap - 1'b1;
	assign d        = {z_q[31], z_q} - {zlo_q[31], zlo_q};
	assign den      = {zhi_q[31], zhi_q} - {zlo_q[31], zlo_q};
	assign den_pos  = !den[32] && (den != '0);
	assign probe_ok = !d[32] && den_pos;
	assign dzc      = d[32] ? '0 : ((d > den) ? den : d);
	assign zp       = $signed(rd_z_q);

	assign sts.count_zero = count_q == '0;
	assign sts.out_range  = (z_q < zlo_q) || (z_q > zp);
	assign sts.gap_gt1    = gap > IDXW'(1);
	assign sts.div_done   = div_done;

	always_comb begin
		unique case (cmd.rd_sel)
			ttint_pkg::RS_HI:    raddr = hi_q;
			ttint_pkg::RS_PROBE: raddr = probe_q;
			default:             raddr = lo_q;
		endcase
	end

	// Probe numerator 2*gap*d + den over 2*den; weight (dz << F) + den/2 over den.
	always_comb begin
		if (cmd.div_weight) begin
			div_num = (NW'(dzc[31:0]) << FRAC_BITS) + NW'(den[31:0] >> 1);
			div_den = DW'(den[31:0]);
		end else begin
			div_num = NW'({prod_s1, 1'b0}) + NW'(den[31:0]);
			div_den = DW'({den[31:0], 1'b0});
		end
	end

	ttint_div #(.NW(NW), .DW(DW), .QB(QB)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (quot)
	);

	// Keep every probe strictly inside the bracket.
	always_comb begin
		off = probe_ok ? quot : '0;
		if (off < QB'(1)) begin
			offc = QB'(1);
		end else if (off > QB'(gapm1)) begin
			offc = QB'(gapm1);
		end else begin
			offc = off;
		end
	end

	always_comb begin
		case (cmd.mul_lane)
			ttint_pkg::LANE_Y: begin
				vlo = lo_y_q;
				vhi = hi_y_q;
			end
			ttint_pkg::LANE_T: begin
				vlo = lo_t_q;
				vhi = hi_t_q;
			end
			default: begin
				vlo = lo_x_q;
				vhi = hi_x_q;
			end
		endcase
	end

	assign one_m_w = {1'b1, {FRAC_BITS{1'b0}}} - w_q;
	assign sum     = {pa_s1[PW-1], pa_s1} + {pb_s1[PW-1], pb_s1}
		+ (PW+1)'({1'b1, {(FRAC_BITS-1){1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
		end else begin
			if (cmd.clr) begin
				count_q <= '0;
			end else if (cmd.wr && !full) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.init_br) begin
				lo_q <= '0;
				hi_q <= IDXW'(count_q - 1'b1);
			end else if (cmd.upd_br) begin
				if (z_q < zp) begin
					hi_q <= probe_q;
				end else if (z_q > zp) begin
					lo_q <= probe_q;
				end else begin
					lo_q <= probe_q;
					hi_q <= probe_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && !full) begin
			mem_x[count_q[IDXW-1:0]] <= in_data[31:0];
			mem_y[count_q[IDXW-1:0]] <= in_data[63:32];
			mem_z[count_q[IDXW-1:0]] <= in_data[95:64];
			mem_t[count_q[IDXW-1:0]] <= in_data[127:96];
		end
		rd_x_q <= mem_x[raddr];
		rd_y_q <= mem_y[raddr];
		rd_z_q <= mem_z[raddr];
		rd_t_q <= mem_t[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_z) begin
			z_q <= $signed(in_data[95:64]);
		end
		if (cmd.cap_lo_row) begin
			lo_x_q <= rd_x_q;
			lo_y_q <= rd_y_q;
			lo_t_q <= rd_t_q;
			zlo_q  <= zp;
		end else if (cmd.upd_br && (z_q >= zp)) begin
			zlo_q <= zp;
		end
		if (cmd.cap_hi_row) begin
			hi_x_q <= rd_x_q;
			hi_y_q <= rd_y_q;
			hi_t_q <= rd_t_q;
			zhi_q  <= zp;
		end else if (cmd.upd_br && (z_q < zp)) begin
			zhi_q <= zp;
		end
		if (cmd.mul_gap) begin
			prod_s1 <= (IDXW+32)'(gap) * (IDXW+32)'(d[31:0]);
		end
		if (cmd.set_probe) begin
			probe_q <= lo_q + offc[IDXW-1:0];
		end
		if (cmd.cap_w) begin
			w_q <= den_pos ? quot[FRAC_BITS:0] : '0;
		end
		if (cmd.mul_en) begin
			pa_s1 <= $signed({1'b0, w_q}) * $signed(vhi);
			pb_s1 <= $signed({1'b0, one_m_w}) * $signed(vlo);
		end
		if (cmd.res_en) begin
			res_status_q <= cmd.res_status;
			res_x_q      <= '0;
			res_y_q      <= '0;
			res_t_q      <= '0;
		end
		if (cmd.sum_en) begin
			case (cmd.sum_lane)
				ttint_pkg::LANE_Y: res_y_q <= sum[FRAC_BITS+31:FRAC_BITS];
				ttint_pkg::LANE_T: res_t_q <= sum[FRAC_BITS+31:FRAC_BITS];
				default:           res_x_q <= sum[FRAC_BITS+31:FRAC_BITS];
			endcase
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_x_q      <= res_x_q;
			out_y_q      <= res_y_q;
			out_t_q      <= res_t_q;
		end
	end

	assign out_status = out_status_q;
	assign out_data   = {out_t_q, out_y_q, out_x_q};

	`TTI_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNTW'(TABLE_DEPTH))
	`TTI_ASSERT_IMP(a_probe_bracket, cmd.set_probe, (lo_q < hi_q) && (gap > IDXW'(1)))
	`TTI_ASSERT_NXT(a_clear_empties, cmd.clr, count_q == '0)

endmodule

/* src/ttint_ctrl.sv */
`include "trajectory_table_interpolator_defines.svh"

module ttint_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_kind,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output ttint_pkg::cmd_t cmd,
	input  ttint_pkg::sts_t sts
);

	typedef enum logic [20:0] {
		S_IDLE  = 21'h000001,
		S_CHK   = 21'h000002,
		S_RLO   = 21'h000004,
		S_RHI   = 21'h000008,
		S_RNG   = 21'h000010,
		S_LOOP  = 21'h000020,
		S_PDIV  = 21'h000040,
		S_PWAIT = 21'h000080,
		S_PSET  = 21'h000100,
		S_PRD   = 21'h000200,
		S_PCMP  = 21'h000400,
		S_FLO   = 21'h000800,
		S_FHI   = 21'h001000,
		S_FCAP  = 21'h002000,
		S_WDIV  = 21'h004000,
		S_WWAIT = 21'h008000,
		S_BX    = 21'h010000,
		S_BY    = 21'h020000,
		S_BT    = 21'h040000,
		S_BE    = 21'h080000,
		S_DONE  = 21'h100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (ttint_pkg::kind_t'(in_kind))
						ttint_pkg::KIND_CLEAR:  cmd.clr = 1'b1;
						ttint_pkg::KIND_APPEND: cmd.wr = 1'b1;
						ttint_pkg::KIND_QUERY: begin
							cmd.load_z = 1'b1;
							state_d    = S_CHK;
						end
						default: ;
					endcase
				end
			end
			S_CHK: begin
				if (sts.count_zero) begin
					cmd.res_en     = 1'b1;
					cmd.res_status = ttint_pkg::ST_EMPTY;
					state_d        = S_DONE;
				end else begin
					cmd.init_br = 1'b1;
					state_d     = S_RLO;
				end
			end
			S_RLO: begin
				cmd.rd_sel = ttint_pkg::RS_LO;
				state_d    = S_RHI;
			end
			S_RHI: begin
				cmd.cap_lo_row = 1'b1;
				cmd.rd_sel     = ttint_pkg::RS_HI;
				state_d        = S_RNG;
			end
			S_RNG: begin
				cmd.cap_hi_row = 1'b1;
				if (sts.out_range) begin
					cmd.res_en     = 1'b1;
					cmd.res_status = ttint_pkg::ST_RANGE;
					state_d        = S_DONE;
				end else begin
					state_d = S_LOOP;
				end
			end
			S_LOOP: begin
				if (sts.gap_gt1) begin
					cmd.mul_gap = 1'b1;
					state_d     = S_PDIV;
				end else begin
					state_d = S_FLO;
				end
			end
			S_PDIV: begin
				cmd.div_start = 1'b1;
				state_d       = S_PWAIT;
			end
			S_PWAIT: begin
				if (sts.div_done) begin
					state_d = S_PSET;
				end
			end
			S_PSET: begin
				cmd.set_probe = 1'b1;
				state_d       = S_PRD;
			end
			S_PRD: begin
				cmd.rd_sel = ttint_pkg::RS_PROBE;
				state_d    = S_PCMP;
			end
			S_PCMP: begin
				cmd.upd_br = 1'b1;
				state_d    = S_LOOP;
			end
			S_FLO: begin
				cmd.rd_sel = ttint_pkg::RS_LO;
				state_d    = S_FHI;
			end
			S_FHI: begin
				cmd.cap_lo_row = 1'b1;
				cmd.rd_sel     = ttint_pkg::RS_HI;
				state_d        = S_FCAP;
			end
			S_FCAP: begin
				cmd.cap_hi_row = 1'b1;
				state_d        = S_WDIV;
			end
			S_WDIV: begin
				cmd.div_start  = 1'b1;
				cmd.div_weight = 1'b1;
				state_d        = S_WWAIT;
			end
			S_WWAIT: begin
				if (sts.div_done) begin
					cmd.cap_w = 1'b1;
					state_d   = S_BX;
				end
			end
			S_BX: begin
				cmd.mul_en     = 1'b1;
				cmd.mul_lane   = ttint_pkg::LANE_X;
				cmd.res_en     = 1'b1;
				cmd.res_status = ttint_pkg::ST_OK;
				state_d        = S_BY;
			end
			S_BY: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_lane = ttint_pkg::LANE_Y;
				cmd.sum_en   = 1'b1;
				cmd.sum_lane = ttint_pkg::LANE_X;
				state_d      = S_BT;
			end
			S_BT: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_lane = ttint_pkg::LANE_T;
				cmd.sum_en   = 1'b1;
				cmd.sum_lane = ttint_pkg::LANE_Y;
				state_d      = S_BE;
			end
			S_BE: begin
				cmd.sum_en   = 1'b1;
				cmd.sum_lane = ttint_pkg::LANE_T;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TTI_ASSERT_IMP(a_done_in_wait, sts.div_done, (state_q == S_PWAIT) || (state_q == S_WWAIT))
	`TTI_ASSERT_NXT(a_load_shows, cmd.out_load, out_valid_q)
	`TTI_ASSERT_IMP(a_no_drop, cmd.out_load, !out_valid_q || out_ready)

endmodule

/* src/trajectory_table_interpolator.sv */
// Clear and append: accepted back to back; no result transaction.
// Query: range check, then P interpolation probes and one weight division on the
//   one-bit-per-cycle divider of QB = max(log2(TABLE_DEPTH), FRAC_BITS) + 1 bits.
// One item at a time; a finished result waits in the output register while the
//   next item is taken.
// arst_n low clears the point count, the state machine and the output valid.
module trajectory_table_interpolator #(
	parameter int unsigned TABLE_DEPTH = 1024,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // pos_x, pos_y, pos_z, pos_t
	input  logic [1:0]   s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,  // out_x, out_y, out_t
	output logic [1:0]   m_axis_tuser   // status
);

	ttint_pkg::cmd_t cmd;
	ttint_pkg::sts_t sts;

	// Controller: sequences clear, append and the query steps
	// (range check, probe loop, weight division, blend, hand-off).
	ttint_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Datapath: point table memories, bracket registers, shared divider,
	// blend multipliers and the output register.
	ttint_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.out_status(m_axis_tuser),
		.out_data  (m_axis_tdata)
	);

endmodule

/* test/tb_trajectory_table_interpolator.sv */
`timescale 1ns / 1ps

module tb_trajectory_table_interpolator;

	localparam int unsigned DEPTH = 1024;
	localparam int unsigned FRAC  = 16;
	localparam int unsigned STALL_LIMIT = 200000;

	typedef struct {
		ttint_pkg::status_t status;
		logic [31:0]        x;
		logic [31:0]        y;
		logic [31:0]        t;
	} answer_t;

	// Scoreboard: holds a shadow of the point table and a queue of pending answers.
	class path_scoreboard;
		longint px[DEPTH];
		longint py[DEPTH];
		longint pz[DEPTH];
		longint pt[DEPTH];
		int unsigned n_points;
		answer_t pending[$];
		int errors;

		function logic [31:0] mix(longint w, longint vlo, longint vhi);
			longint s;
			s = w * vhi + ((longint'(1) <<< FRAC) - w) * vlo + (longint'(1) <<< (FRAC - 1));
			return 32'(s >>> FRAC);
		endfunction

		// Append an answer at the tail of the pending queue.
		function void add_answer(answer_t a);
			pending = {pending, a};
		endfunction

		// Note an accepted input transaction; queries push one answer.
		function void note_item(ttint_pkg::kind_t k, logic [31:0] ix, logic [31:0] iy,
				logic [31:0] iz, logic [31:0] it);
			answer_t a;
			longint z, d, span, dz, w, off, zp;
			int unsigned lo, hi, gap, probe;
			z = longint'($signed(iz));
			if (k == ttint_pkg::KIND_CLEAR) begin
				n_points = 0;
				return;
			end
			if (k == ttint_pkg::KIND_APPEND) begin
				if (n_points < DEPTH) begin
					px[n_points] = $signed(ix);
					py[n_points] = $signed(iy);
					pz[n_points] = z;
					pt[n_points] = $signed(it);
					n_points++;
				end
				return;
			end
			if (k != ttint_pkg::KIND_QUERY)
				return;
			a.x = 0;
			a.y = 0;
			a.t = 0;
			if (n_points == 0) begin
				a.status = ttint_pkg::ST_EMPTY;
				add_answer(a);
				return;
			end
			lo = 0;
			hi = n_points - 1;
			if (z < pz[lo] || z > pz[hi]) begin
				a.status = ttint_pkg::ST_RANGE;
				add_answer(a);
				return;
			end
			while (hi - lo > 1) begin
				gap = hi - lo;
				off = 0;
				d = z - pz[lo];
				span = pz[hi] - pz[lo];
				if (d >= 0 && span > 0)
					off = (2 * longint'(gap) * d + span) / (2 * span);
				if (off < 1)
					off = 1;
				if (off > gap - 1)
					off = gap - 1;
				probe = lo + int'(off);
				zp = pz[probe];
				if (z < zp)
					hi = probe;
				else if (z > zp)
					lo = probe;
				else begin
					lo = probe;
					hi = probe + 1;
				end
			end
			span = pz[hi] - pz[lo];
			w = 0;
			if (span > 0) begin
				dz = z - pz[lo];
				if (dz < 0)
					dz = 0;
				if (dz > span)
					dz = span;
				w = ((dz <<< FRAC) + (span >>> 1)) / span;
			end
			a.status = ttint_pkg::ST_OK;
			a.x = mix(w, px[lo], px[hi]);
			a.y = mix(w, py[lo], py[hi]);
			a.t = mix(w, pt[lo], pt[hi]);
			add_answer(a);
		endfunction

		// Compare a result transaction with the oldest pending answer.
		function void check_result(logic [1:0] st, logic [95:0] d);
			answer_t a;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d data=%h", $time, st, d);
				errors++;
				return;
			end
			a = pending.pop_front();
			if (st !== a.status) begin
				$display("%0t: status expected %0d actual %0d", $time, a.status, st);
				errors++;
			end
			if (d[31:0] !== a.x) begin
				$display("%0t: out_x expected %h actual %h", $time, a.x, d[31:0]);
				errors++;
			end
			if (d[63:32] !== a.y) begin
				$display("%0t: out_y expected %h actual %h", $time, a.y, d[63:32]);
				errors++;
			end
			if (d[95:64] !== a.t) begin
				$display("%0t: out_t expected %h actual %h", $time, a.t, d[95:64]);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;  // pos_x, pos_y, pos_z, pos_t
	logic [1:0]   s_axis_tuser = '0;  // kind
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [95:0]  m_axis_tdata;       // out_x, out_y, out_t
	logic [1:0]   m_axis_tuser;       // status

	path_scoreboard sb = new();
	bit quiet_sink;      // stretches with no stall on the result side
	bit quiet_source;    // stretches with no gap on the item side
	int unsigned idle_cycles;

	trajectory_table_interpolator dut (.*);

	always #2 clk = ~clk;

	// Watchdog: count cycles without any transaction.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("tb_trajectory_table_interpolator: errors");
			$finish;
		end
	end

	// Result side: sample at the rising edge, draw a fresh stall after each transaction.
	initial begin : sink
		int unsigned wait_n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			wait_n = quiet_sink ? 0 : $urandom_range(0, 18);
			repeat (wait_n) @(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tuser, m_axis_tdata);
			@(negedge clk);
			m_axis_tready <= 1'b0;
		end
	end

	// Send one item; lower valid only when the next item is not immediately ready.
	task automatic send_item(ttint_pkg::kind_t k, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] t);
		int unsigned gap_n;
		gap_n = quiet_source ? 0 : $urandom_range(0, 18);
		if (gap_n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap_n) @(negedge clk);
		end
		s_axis_tuser  <= k;
		s_axis_tdata  <= {t, z, y, x};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(k, x, y, z, t);
		@(negedge clk);
	endtask

	task automatic send_raw_kind(logic [1:0] k, logic [127:0] d);
		s_axis_tuser  <= k;
		s_axis_tdata  <= d;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(ttint_pkg::kind_t'(k), d[31:0], d[63:32], d[95:64], d[127:96]);
		@(negedge clk);
	endtask

	// Build a sorted table of n points from a random start and random steps.
	task automatic load_track(int unsigned n, int unsigned max_step);
		logic [31:0] z;
		z = $urandom;
		z = {z[31], z[31] ? 7'h7f : 7'h00, z[23:0]};
		send_item(ttint_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
		for (int unsigned i = 0; i < n; i++) begin
			send_item(ttint_pkg::KIND_APPEND, $urandom, $urandom, z, $urandom);
			z = z + $urandom_range(0, max_step);
		end
	endtask

	task automatic query_z(logic [31:0] z);
		send_item(ttint_pkg::KIND_QUERY, $urandom, $urandom, z, $urandom);
	endtask

	initial begin : stimulus
		logic [31:0] zq;
		int unsigned n_items;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty table, single point, extremes, unused kind.
		query_z(32'h0);
		send_item(ttint_pkg::KIND_APPEND, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h7fffffff);
		query_z(32'h80000000);
		query_z(32'h80000001);
		send_item(ttint_pkg::KIND_APPEND, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h80000000);
		query_z(32'h0);
		query_z(32'h7fffffff);
		query_z(32'h80000000);
		send_raw_kind(2'd3, {4{32'hffffffff}});
		query_z(32'h12345678);
		// Equal bracket z: duplicate points.
		send_item(ttint_pkg::KIND_CLEAR, 0, 0, 0, 0);
		send_item(ttint_pkg::KIND_APPEND, 32'h10000, 32'h20000, 32'h5000, 32'h30000);
		send_item(ttint_pkg::KIND_APPEND, 32'h40000, 32'h50000, 32'h5000, 32'h60000);
		send_item(ttint_pkg::KIND_APPEND, 32'h70000, 32'h80000, 32'h5000, 32'h90000);
		query_z(32'h5000);
		query_z(32'h4fff);
		// Unsorted table: first and last define span, middle out of order.
		send_item(ttint_pkg::KIND_APPEND, 32'h1, 32'h2, 32'h1000, 32'h3);
		send_item(ttint_pkg::KIND_APPEND, 32'h4, 32'h5, 32'h9000, 32'h6);
		send_item(ttint_pkg::KIND_APPEND, 32'h7, 32'h8, 32'h2000, 32'h9);
		query_z(32'h6000);
		query_z(32'h1800);
		send_item(ttint_pkg::KIND_CLEAR, 0, 0, 0, 0);
		query_z(32'h0);

		// Full table: fill past capacity once, fast, then probe it.
		quiet_source = 1;
		load_track(DEPTH + 3, 32'h200);
		quiet_source = 0;
		for (int i = 0; i < 6; i++)
			query_z(sb.pz[0] + $urandom_range(0, 32'h200 * (DEPTH - 1)));
		query_z(sb.pz[DEPTH - 1]);

		// Random: mostly small sorted tracks with queries inside the span.
		n_items = 0;
		while (n_items < 550) begin
			int unsigned n;
			quiet_source = ($urandom_range(0, 3) == 0);
			quiet_sink   = ($urandom_range(0, 3) == 0);
			n = $urandom_range(0, 12);
			load_track(n, ($urandom_range(0, 1) ? 32'hffff : 32'h3));
			n_items += n + 1;
			for (int q = 0; q < 8; q++) begin
				case ($urandom_range(0, 9))
					0: zq = $urandom;
					1: zq = (n > 0) ? sb.pz[$urandom_range(0, n - 1)] : $urandom;
					2: begin
						send_item(ttint_pkg::KIND_APPEND, $urandom, $urandom,
							$urandom, $urandom);
						n_items++;
						zq = $urandom;
					end
					3: begin
						send_raw_kind(2'd3, {$urandom, $urandom, $urandom, $urandom});
						zq = $urandom;
					end
					default: zq = (n > 1) ? sb.pz[0] + $urandom_range(0,
						sb.pz[n - 1] - sb.pz[0]) : $urandom;
				endcase
				query_z(zq);
				n_items++;
			end
		end
		s_axis_tvalid <= 1'b0;
		quiet_sink = 0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_trajectory_table_interpolator: clean");
		else
			$display("tb_trajectory_table_interpolator: errors");
		$finish;
	end
endmodule
